FILE: rtl/pdet_pkg.sv
// Shared types and constants for the path distance event trigger.
// Command and result words, config register map, sequencer states.
// No dependencies.
package pdet_pkg;

  localparam int MARKS_DEF = 16;
  localparam int KINDS_DEF = 8;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_LEAD     = 2'd2,
    OP_POSITION = 2'd3
  } op_t;

  localparam logic [1:0] REG_PATH_READY  = 2'd0;
  localparam logic [1:0] REG_MAX_LEAD    = 2'd1;
  localparam logic [1:0] REG_KIND_ENABLE = 2'd2;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] distance;
    logic [7:0]         kind_mask;
    logic [2:0]         kind_index;
    logic [30:0]        lead;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] mark_index;
    logic [7:0] fired;
    logic [4:0] resume_index;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [3:0] mark_index;
    logic [7:0] fired;
  } hit_t;

  typedef struct packed {
    logic        path_ready;
    logic [30:0] max_lead;
    logic [7:0]  kind_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_KIND,
    ST_WRITE,
    ST_FETCH,
    ST_SHOW_ONE,
    ST_SHOW_RES
  } state_t;

endpackage

FILE: rtl/path_distance_event_trigger.sv
// Path distance event trigger: configuration registers and the sequencer.
// Uses pdet_pkg and pdet_ctrl.
//
// The block takes one command word at a time and is not ready until every
// result word of that command has been taken. Clear, append and lead words
// give one result word in the cycle after they are taken. A position word
// walks the mark table from the resume index through one shared 34-bit
// subtract and compare unit: a mark with no kinds left takes a table read
// and a bound check, any other scanned mark a table read, a bound check, one
// kind per cycle and a write back. The stop comes at a table read or a bound
// check, and each fired mark is then read from the result queue and handed
// out as a result word, held until it is taken. Register reads and writes use
// the APB port at any time; writes are meant for when the block is idle.
module path_distance_event_trigger #(
  parameter int MARKS = pdet_pkg::MARKS_DEF,
  parameter int KINDS = pdet_pkg::KINDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  pdet_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  output pdet_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_ready
);

  pdet_pkg::cfg_t cfg;
  logic           reg_we;

  assign pready = 1'b1;
  assign reg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (reg_we) begin
      unique case (paddr[3:2])
        pdet_pkg::REG_PATH_READY:  cfg.path_ready  <= pwdata[0];
        pdet_pkg::REG_MAX_LEAD:    cfg.max_lead    <= pwdata[30:0];
        pdet_pkg::REG_KIND_ENABLE: cfg.kind_enable <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pdet_pkg::REG_PATH_READY:  prdata = {31'd0, cfg.path_ready};
      pdet_pkg::REG_MAX_LEAD:    prdata = {1'b0, cfg.max_lead};
      pdet_pkg::REG_KIND_ENABLE: prdata = {24'd0, cfg.kind_enable};
      default:                   prdata = '0;
    endcase
  end

  pdet_ctrl #(.MARKS(MARKS), .KINDS(KINDS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  a_no_cmd_while_res: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !cmd_ready)
    else $error("command taken while a result word is pending");

  a_reject_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.accepted |-> res.last_of_run)
    else $error("rejected word not last of run");

  a_fire_accepted: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.fired != 8'd0) |-> res.accepted)
    else $error("kinds fired on a word not accepted");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last_of_run |=> cmd_ready)
    else $error("not ready after last result word");

endmodule

FILE: rtl/pdet_table.sv
// Mark table: distance and kind mask memories, one write and one read port.
// Read data is registered. Depends on nothing beyond its parameters.
module pdet_table #(
  parameter int MARKS = 16,
  parameter int KINDS = 8,
  localparam int IW = (MARKS > 1) ? $clog2(MARKS) : 1
) (
  input  logic                    clk,
  input  logic                    we_mark,
  input  logic                    we_kinds,
  input  logic [IW-1:0]           waddr,
  input  logic signed [31:0]      wdist,
  input  logic [KINDS-1:0]        wkinds,
  input  logic [IW-1:0]           raddr,
  output logic signed [31:0]      rdist,
  output logic [KINDS-1:0]        rkinds
);

  logic signed [31:0] dist_mem  [MARKS];
  logic [KINDS-1:0]   kinds_mem [MARKS];

  always_ff @(posedge clk) begin
    if (we_mark) begin
      dist_mem[waddr] <= wdist;
    end
    if (we_mark || we_kinds) begin
      kinds_mem[waddr] <= wkinds;
    end
    rdist  <= dist_mem[raddr];
    rkinds <= kinds_mem[raddr];
  end

endmodule

FILE: rtl/pdet_cmp.sv
// Shared distance compare: tells whether mark distance minus a lead lies
// below the position. Exact at 34 bits. No dependencies.
module pdet_cmp (
  input  logic signed [31:0] mark_dist,
  input  logic [30:0]        lead,
  input  logic signed [31:0] pos,
  output logic               below
);

  logic signed [33:0] diff;

  assign diff  = 34'(mark_dist) - $signed({3'b000, lead});
  assign below = diff < 34'(pos);

endmodule

FILE: rtl/pdet_resq.sv
// Result queue: holds the marks fired by one position word until the scan
// ends. Uses pdet_pkg for the entry type.
module pdet_resq #(
  parameter int MARKS = 16,
  localparam int IW = (MARKS > 1) ? $clog2(MARKS) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  pdet_pkg::hit_t    wdata,
  input  logic              re,
  input  logic [IW-1:0]     raddr,
  output pdet_pkg::hit_t    rdata
);

  pdet_pkg::hit_t mem [MARKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pdet_ctrl.sv
// Sequencer: decodes command words, walks the mark table through the
// shared compare unit, queues hits and hands out result words.
// Uses pdet_pkg, pdet_table, pdet_cmp and pdet_resq.
module pdet_ctrl #(
  parameter int MARKS = pdet_pkg::MARKS_DEF,
  parameter int KINDS = pdet_pkg::KINDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pdet_pkg::cfg_t cfg,
  input  pdet_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  output pdet_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_ready
);

  localparam int IW = (MARKS > 1) ? $clog2(MARKS) : 1;
  localparam int CW = $clog2(MARKS + 1);
  localparam int KW = (KINDS > 1) ? $clog2(KINDS) : 1;

  pdet_pkg::state_t state, state_next, fin_state;

  logic [CW-1:0]      mark_count;
  logic [CW-1:0]      scan_start;
  logic [30:0]        lead_r [KINDS];
  logic signed [31:0] last_dist;
  logic signed [31:0] pos;
  logic [CW-1:0]      i;
  logic [KW-1:0]      j;
  logic [KINDS-1:0]   f;
  logic [CW-1:0]      n;
  logic [CW-1:0]      k;
  logic               run;
  logic               acc;

  logic               append_ok;
  logic               lead_ok;
  logic               below;
  logic [30:0]        cmp_lead;
  logic               fire_bit;
  logic               is_last;
  logic [KINDS-1:0]   new_kinds;

  logic               tbl_we_mark;
  logic               tbl_we_kinds;
  logic [IW-1:0]      tbl_waddr;
  logic signed [31:0] tbl_wdist;
  logic [KINDS-1:0]   tbl_wkinds;
  logic signed [31:0] rd_dist;
  logic [KINDS-1:0]   rd_kinds;

  logic               q_we;
  logic               q_re;
  pdet_pkg::hit_t     q_wdata;
  pdet_pkg::hit_t     q_rdata;

  assign append_ok = (mark_count < CW'(MARKS)) &&
                     ((mark_count == '0) || (cmd.distance > last_dist));
  assign lead_ok   = {29'd0, cmd.kind_index} < 32'(KINDS);
  assign cmp_lead  = (state == pdet_pkg::ST_KIND) ? lead_r[j] : cfg.max_lead;
  assign fire_bit  = rd_kinds[j] && below && (32'(j) < 32'd8) &&
                     cfg.kind_enable[3'(j)];
  assign new_kinds = rd_kinds & ~f;
  assign is_last   = (k + CW'(1)) == n;
  assign fin_state = (n == '0) ? pdet_pkg::ST_SHOW_ONE : pdet_pkg::ST_FETCH;

  pdet_table #(.MARKS(MARKS), .KINDS(KINDS)) u_table (
    .clk      (clk),
    .we_mark  (tbl_we_mark),
    .we_kinds (tbl_we_kinds),
    .waddr    (tbl_waddr),
    .wdist    (tbl_wdist),
    .wkinds   (tbl_wkinds),
    .raddr    (i[IW-1:0]),
    .rdist    (rd_dist),
    .rkinds   (rd_kinds)
  );

  pdet_cmp u_cmp (
    .mark_dist (rd_dist),
    .lead      (cmp_lead),
    .pos       (pos),
    .below     (below)
  );

  pdet_resq #(.MARKS(MARKS)) u_resq (
    .clk   (clk),
    .we    (q_we),
    .waddr (n[IW-1:0]),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (k[IW-1:0]),
    .rdata (q_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      pdet_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == pdet_pkg::OP_POSITION && cfg.path_ready) begin
            state_next = pdet_pkg::ST_READ;
          end else begin
            state_next = pdet_pkg::ST_SHOW_ONE;
          end
        end
      end
      pdet_pkg::ST_READ: begin
        if (i >= mark_count) begin
          state_next = fin_state;
        end else begin
          state_next = pdet_pkg::ST_CHECK;
        end
      end
      pdet_pkg::ST_CHECK: begin
        if (!below) begin
          state_next = fin_state;
        end else if (rd_kinds == '0) begin
          state_next = pdet_pkg::ST_READ;
        end else begin
          state_next = pdet_pkg::ST_KIND;
        end
      end
      pdet_pkg::ST_KIND: begin
        if (j == KW'(KINDS - 1)) begin
          state_next = pdet_pkg::ST_WRITE;
        end
      end
      pdet_pkg::ST_WRITE: state_next = pdet_pkg::ST_READ;
      pdet_pkg::ST_FETCH: state_next = pdet_pkg::ST_SHOW_RES;
      pdet_pkg::ST_SHOW_ONE: begin
        if (res_ready) begin
          state_next = pdet_pkg::ST_IDLE;
        end
      end
      pdet_pkg::ST_SHOW_RES: begin
        if (res_ready) begin
          state_next = is_last ? pdet_pkg::ST_IDLE : pdet_pkg::ST_FETCH;
        end
      end
      default: state_next = pdet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready    = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    tbl_we_mark  = 1'b0;
    tbl_we_kinds = 1'b0;
    tbl_waddr    = i[IW-1:0];
    tbl_wdist    = cmd.distance;
    tbl_wkinds   = new_kinds;
    q_we         = 1'b0;
    q_re         = 1'b0;
    q_wdata      = '{mark_index: 4'(i), fired: 8'(f)};
    unique case (state)
      pdet_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid && cmd.op == pdet_pkg::OP_APPEND && append_ok) begin
          tbl_we_mark = 1'b1;
          tbl_waddr   = mark_count[IW-1:0];
          tbl_wkinds  = KINDS'(cmd.kind_mask);
        end
      end
      pdet_pkg::ST_WRITE: begin
        tbl_we_kinds = 1'b1;
        q_we         = (f != '0);
      end
      pdet_pkg::ST_FETCH: q_re = 1'b1;
      pdet_pkg::ST_SHOW_ONE: begin
        res_valid        = 1'b1;
        res.accepted     = acc;
        res.resume_index = 5'(scan_start);
        res.last_of_run  = 1'b1;
      end
      pdet_pkg::ST_SHOW_RES: begin
        res_valid        = 1'b1;
        res.accepted     = 1'b1;
        res.mark_index   = q_rdata.mark_index;
        res.fired        = q_rdata.fired;
        res.resume_index = 5'(scan_start);
        res.last_of_run  = is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pdet_pkg::ST_IDLE;
      mark_count <= '0;
      scan_start <= '0;
      i          <= '0;
      j          <= '0;
      f          <= '0;
      n          <= '0;
      k          <= '0;
      run        <= 1'b0;
      acc        <= 1'b0;
      for (int q = 0; q < KINDS; q++) begin
        lead_r[q] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        pdet_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              pdet_pkg::OP_CLEAR: begin
                mark_count <= '0;
                scan_start <= '0;
                acc        <= 1'b1;
              end
              pdet_pkg::OP_APPEND: begin
                acc <= append_ok;
                if (append_ok) begin
                  mark_count <= mark_count + CW'(1);
                  last_dist  <= cmd.distance;
                end
              end
              pdet_pkg::OP_LEAD: begin
                acc <= lead_ok;
                if (lead_ok) begin
                  lead_r[KW'(cmd.kind_index)] <= cmd.lead;
                end
              end
              pdet_pkg::OP_POSITION: begin
                acc <= cfg.path_ready;
                pos <= cmd.distance;
                i   <= scan_start;
                n   <= '0;
                k   <= '0;
                run <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        pdet_pkg::ST_CHECK: begin
          j <= '0;
          f <= '0;
          if (below && rd_kinds == '0) begin
            i <= i + CW'(1);
          end
        end
        pdet_pkg::ST_KIND: begin
          if (fire_bit) begin
            f[j] <= 1'b1;
          end
          j <= j + KW'(1);
        end
        pdet_pkg::ST_WRITE: begin
          if (f != '0) begin
            n <= n + CW'(1);
          end
          if (run) begin
            if (new_kinds == '0) begin
              scan_start <= i + CW'(1);
            end else begin
              run <= 1'b0;
            end
          end
          i <= i + CW'(1);
        end
        pdet_pkg::ST_SHOW_RES: begin
          if (res_ready) begin
            k <= k + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
